[rtl/itp_pkg.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter package
// Shared constants, token and result types, and operator priority tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PRIO_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PLUS   = 3'd0,
    OP_MINUS  = 3'd1,
    OP_TIMES  = 3'd2,
    OP_DIVIDE = 3'd3,
    OP_OPEN   = 3'd4,
    OP_CLOSE  = 3'd5,
    OP_END    = 3'd6
  } op_code_e;

  typedef enum logic {
    TOK_OPERAND  = 1'b0,
    TOK_OPERATOR = 1'b1
  } tok_kind_e;

  typedef enum logic [2:0] {
    ACT_OPERAND,
    ACT_PUSH,
    ACT_OVERFLOW,
    ACT_POP,
    ACT_DISCARD,
    ACT_END,
    ACT_SKIP
  } step_act_e;

  typedef logic [PRIO_W-1:0] prio_t;

  typedef struct packed {
    tok_kind_e                     kind;
    logic signed [VALUE_WIDTH-1:0] value;
    op_code_e                      code;
    prio_t                         icp;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_port_t;

  typedef struct packed {
    logic                          is_operand;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [2:0]                    op;
    logic                          last;
    logic                          expr_done;
    logic                          overflow;
  } result_t;

  function automatic prio_t in_stack_prio(op_code_e code);
    prio_t p;
    unique case (code)
      OP_PLUS, OP_MINUS:   p = prio_t'(3);
      OP_TIMES, OP_DIVIDE: p = prio_t'(5);
      OP_OPEN:             p = prio_t'(1);
      OP_CLOSE:            p = prio_t'(6);
      OP_END:              p = prio_t'(0);
      default:             p = prio_t'(0);
    endcase
    return p;
  endfunction

  function automatic prio_t incoming_prio(op_code_e code);
    prio_t p;
    unique case (code)
      OP_PLUS, OP_MINUS:   p = prio_t'(2);
      OP_TIMES, OP_DIVIDE: p = prio_t'(4);
      OP_OPEN:             p = prio_t'(6);
      OP_CLOSE:            p = prio_t'(1);
      OP_END:              p = prio_t'(0);
      default:             p = prio_t'(0);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/itp_if.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter channel interfaces
// Valid/ready channels for incoming tokens and outgoing postfix results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itp_token_if;
  import itp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [VALUE_WIDTH-1:0] operand_value;
  logic [2:0]                    operator_code;

  modport source (output valid, func, operand_value, operator_code, input ready);
  modport sink (input valid, func, operand_value, operator_code, output ready);
endinterface

interface itp_result_if;
  import itp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          out_is_operand;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic [2:0]                    out_operator;
  logic                          last;
  logic                          expr_done;
  logic                          overflow;

  modport source (
    output valid, out_is_operand, out_value, out_operator, last, expr_done, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_is_operand, out_value, out_operator, last, expr_done, overflow,
    output ready
  );
endinterface

`default_nettype wire

[rtl/itp_front.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter front end
// Accepts tokens, drops unknown operator codes and tags each queued token
// with its kind and incoming priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_front (
  itp_token_if.sink             token_i,
  input  wire logic             queue_full_i,
  output itp_pkg::queue_port_t  push_o
);
  import itp_pkg::*;

  logic known_code;

  assign token_i.ready = !queue_full_i;
  assign known_code    = token_i.operator_code <= 3'(OP_END);

  always_comb begin
    push_o.entry.kind  = token_i.func ? TOK_OPERATOR : TOK_OPERAND;
    push_o.entry.value = token_i.operand_value;
    push_o.entry.code  = op_code_e'(token_i.operator_code);
    push_o.entry.icp   = incoming_prio(op_code_e'(token_i.operator_code));
    push_o.valid       = token_i.valid && token_i.ready && (!token_i.func || known_code);
  end

endmodule

`default_nettype wire

[rtl/itp_fifo.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter token queue
// Short queue that decouples token intake from the stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  itp_pkg::queue_port_t push_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output itp_pkg::queue_port_t head_o
);
  import itp_pkg::*;

  queue_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i.valid) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign full_o       = count_q == QCNT_W'(QUEUE_DEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/itp_back.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter stack engine
// Runs one shunting-yard step per cycle on the queue head unless a held result
// waits on a stalled output, holds the newest result until its end-of-token
// flag is known, and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module itp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  itp_pkg::queue_port_t head_i,
  output logic                 pop_o,
  itp_result_if.source         result_o
);
  import itp_pkg::*;

  op_code_e         stack_q [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] top_idx;
  op_code_e         top;
  prio_t            top_prio;
  step_act_e        act;
  logic             hold_valid_q, hold_valid_d;
  result_t          hold_q, hold_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic             out_load;
  logic             out_free;
  logic             step;
  logic             push_en;
  result_t          res;

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign top_idx  = cnt_m1[IDX_W-1:0];
  assign top      = stack_q[top_idx];
  assign top_prio = in_stack_prio(top);
  assign out_free = !out_valid_q || result_o.ready;
  assign step     = head_i.valid && (!hold_valid_q || out_free);

  always_comb begin
    if (head_i.entry.kind == TOK_OPERAND) begin
      act = ACT_OPERAND;
    end else if (top_prio < head_i.entry.icp) begin
      act = (cnt_q == CNT_W'(STACK_DEPTH)) ? ACT_OVERFLOW : ACT_PUSH;
    end else if (top_prio > head_i.entry.icp) begin
      act = ACT_POP;
    end else if (top == OP_OPEN) begin
      act = ACT_DISCARD;
    end else if (top == OP_END) begin
      act = ACT_END;
    end else begin
      act = ACT_SKIP;
    end
  end

  always_comb begin
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_load     = 1'b0;
    out_d        = hold_q;
    push_en      = 1'b0;
    pop_o        = 1'b0;
    res          = '0;

    if (step) begin
      unique case (act)
        ACT_OPERAND, ACT_OVERFLOW, ACT_END, ACT_POP: begin
          res.is_operand = act == ACT_OPERAND;
          res.value      = (act == ACT_OPERAND) ? head_i.entry.value : '0;
          res.last       = act != ACT_POP;
          res.expr_done  = act == ACT_END;
          res.overflow   = act == ACT_OVERFLOW;
          if (act == ACT_POP) begin
            res.op = top;
            cnt_d  = cnt_m1;
          end else if (act == ACT_END) begin
            res.op = OP_END;
            cnt_d  = CNT_W'(1);
          end else if (act == ACT_OVERFLOW) begin
            res.op = head_i.entry.code;
          end
          pop_o        = act != ACT_POP;
          out_load     = hold_valid_q;
          hold_valid_d = 1'b1;
          hold_d       = res;
        end
        ACT_PUSH, ACT_DISCARD: begin
          if (act == ACT_PUSH) begin
            push_en = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            cnt_d = cnt_m1;
          end
          pop_o        = 1'b1;
          out_load     = hold_valid_q;
          out_d.last   = 1'b1;
          hold_valid_d = 1'b0;
        end
        ACT_SKIP: begin
          cnt_d = cnt_m1;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end else if (hold_valid_q && hold_q.last && out_free) begin
      out_load     = 1'b1;
      hold_valid_d = 1'b0;
    end

    out_valid_d = out_load || (out_valid_q && !result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_q[i] <= (i == 0) ? OP_END : OP_PLUS;
      end
      cnt_q        <= CNT_W'(1);
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push_en) begin
        stack_q[cnt_q[IDX_W-1:0]] <= head_i.entry.code;
      end
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.out_is_operand = out_q.is_operand;
  assign result_o.out_value      = out_q.value;
  assign result_o.out_operator   = out_q.op;
  assign result_o.last           = out_q.last;
  assign result_o.expr_done      = out_q.expr_done;
  assign result_o.overflow       = out_q.overflow;

endmodule

`default_nettype wire

[rtl/infix_to_postfix_converter_core.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter core
// Converts a stream of lexed tokens into postfix order with an operator stack.
//
// Tokens enter on token_i and postfix results leave on result_o, both
// valid/ready channels; a transaction happens when valid and ready are high
// at a rising clock edge. Each token yields zero or more results, and the
// final one of a token carries last. An end token drains the stack, emits the
// end marker with expr_done set and re-arms the stack.
// An operand passes through the queue, the hold register and the output register.
// The stack engine does one step per cycle unless a held result waits on a
// stalled receiver; an operand takes one step and an operator takes one step
// plus one per entry it pops and one per stray close paren that an open paren
// removes from under it. A popped result waits in a hold register until the
// next step shows whether it is the last one of its token.
// Reset sets the stack to the end marker alone and empties the queue.
// When the receiver stalls, the output register holds its transaction, the
// engine stops, and token_i.ready drops once the two-entry queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  itp_token_if.sink    token_i,
  itp_result_if.source result_o
);
  import itp_pkg::*;

  queue_port_t push;
  queue_port_t head;
  logic        queue_full;
  logic        queue_pop;

  itp_front u_front (
    .token_i      (token_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  itp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (queue_pop),
    .full_o (queue_full),
    .head_o (head)
  );

  itp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (queue_pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[test/infix_to_postfix_converter_core_tb.sv]
// ----------------------------------------------------------------------------
// Infix-to-postfix converter core testbench
// Sends lexed tokens through the converter and checks every postfix result
// against an operator-stack predictor. The token sender idles in bursts, and
// the result receiver stalls on a pattern of its own. The run starts with
// directed expressions and then moves to random expressions, broken
// sequences and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter_core_tb;
  import itp_pkg::*;

  localparam logic [2:0] CODE_UNUSED = 3'd7;
  localparam int unsigned MAX_REPORTS = 50;
  localparam int unsigned ROUNDS = 4;
  localparam int unsigned ROUND_TOKENS = 80;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    tok_kind_e                     kind;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [2:0]                    code;
  } token_t;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_e;

  class postfix_scoreboard;
    op_code_e     operator_stack [STACK_DEPTH];
    int unsigned  stack_used;
    result_t      pending_postfix_q [$];
    byte unsigned rank_on_stack [7] = '{3, 3, 5, 5, 1, 6, 0};
    byte unsigned rank_arriving [7] = '{2, 2, 4, 4, 6, 1, 0};
    int unsigned  errors;
    int unsigned  tokens;
    int unsigned  results;
    int unsigned  exprs_done;
    int unsigned  pushes_dropped;

    function new();
      rearm();
    endfunction

    function void rearm();
      foreach (operator_stack[i]) operator_stack[i] = OP_PLUS;
      operator_stack[0] = OP_END;
      stack_used = 1;
    endfunction

    function int unsigned pending();
      return pending_postfix_q.size();
    endfunction

    function void expect_result(result_t r);
      pending_postfix_q.insert(pending_postfix_q.size(), r);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
      if (errors == MAX_REPORTS) $display("Further mismatches are not shown.");
    endfunction

    // Expands one accepted token into the postfix results it must produce.
    function void note_token(token_t t);
      op_code_e code;
      op_code_e top;
      result_t  r;
      bit       popped;
      tokens++;
      if (t.kind == TOK_OPERAND) begin
        r = '0;
        r.is_operand = 1'b1;
        r.value = t.value;
        r.last = 1'b1;
        expect_result(r);
        return;
      end
      if (t.code == CODE_UNUSED) return;
      code = op_code_e'(t.code);
      popped = 1'b0;
      forever begin
        top = operator_stack[stack_used - 1];
        if (rank_on_stack[top] < rank_arriving[code]) begin
          if (stack_used >= STACK_DEPTH) begin
            r = '0;
            r.op = code;
            r.last = 1'b1;
            r.overflow = 1'b1;
            expect_result(r);
            return;
          end
          operator_stack[stack_used] = code;
          stack_used++;
          break;
        end else if (rank_on_stack[top] > rank_arriving[code]) begin
          r = '0;
          r.op = top;
          expect_result(r);
          popped = 1'b1;
          stack_used--;
        end else if (top == OP_OPEN) begin
          stack_used--;
          break;
        end else if (top == OP_END) begin
          rearm();
          r = '0;
          r.op = OP_END;
          r.last = 1'b1;
          r.expr_done = 1'b1;
          expect_result(r);
          return;
        end else begin
          // A stray close paren on top is removed silently by an open paren.
          stack_used--;
        end
      end
      if (popped) begin
        pending_postfix_q[pending_postfix_q.size() - 1].last = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_error($sformatf("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (got.expr_done === 1'b1) exprs_done++;
      if (got.overflow === 1'b1) pushes_dropped++;
      if (pending_postfix_q.size() == 0) begin
        note_error($sformatf("%0t: unexpected result, expected none, actual %p",
                             $time, got));
        return;
      end
      want = pending_postfix_q.pop_front();
      compare_field("out_is_operand", want.is_operand, got.is_operand);
      compare_field("out_value", want.value, got.value);
      compare_field("out_operator", want.op, got.op);
      compare_field("last", want.last, got.last);
      compare_field("expr_done", want.expr_done, got.expr_done);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  itp_token_if  tok_if ();
  itp_result_if res_if ();

  infix_to_postfix_converter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .token_i  (tok_if),
    .result_o (res_if)
  );

  postfix_scoreboard postfix_sb = new();
  token_t            plan_q [$];
  int unsigned       burst_left = 0;
  rx_mode_e          rx_mode = RX_STEADY;
  int unsigned       rx_left = 0;
  int unsigned       rx_phase = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    res_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_STEADY, RX_EVERY_THIRD));
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_STEADY:      res_if.ready = 1'b1;
      RX_COIN:        res_if.ready = 1'($urandom_range(0, 1));
      RX_SPARSE:      res_if.ready = ($urandom_range(0, 3) == 0);
      RX_EVERY_THIRD: res_if.ready = (rx_phase % 3 == 0);
      default:        res_if.ready = 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      r.is_operand = res_if.out_is_operand;
      r.value = res_if.out_value;
      r.op = res_if.out_operator;
      r.last = res_if.last;
      r.expr_done = res_if.expr_done;
      r.overflow = res_if.overflow;
      postfix_sb.check_result(r);
    end
  end

  function automatic void plan_token(token_t t);
    plan_q.insert(plan_q.size(), t);
  endfunction

  function automatic void add_operand(logic signed [VALUE_WIDTH-1:0] value);
    token_t t;
    t.kind = TOK_OPERAND;
    t.value = value;
    t.code = 3'($urandom_range(0, 7));
    plan_token(t);
  endfunction

  function automatic void add_operator(logic [2:0] code);
    token_t t;
    t.kind = TOK_OPERATOR;
    t.value = $urandom;
    t.code = code;
    plan_token(t);
  endfunction

  function automatic void add_noise();
    token_t t;
    t.kind = tok_kind_e'($urandom_range(0, 1));
    t.value = $urandom;
    t.code = 3'($urandom_range(0, 7));
    plan_token(t);
  endfunction

  function automatic void add_expr(int level, int max_level, bit deep);
    int terms;
    bit nest;
    terms = deep ? $urandom_range(1, 2) : $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_operator(3'($urandom_range(OP_PLUS, OP_DIVIDE)));
      nest = deep ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      if (level < max_level && nest) begin
        add_operator(OP_OPEN);
        add_expr(level + 1, max_level, deep);
        add_operator(OP_CLOSE);
      end else begin
        add_operand($urandom);
      end
    end
  endfunction

  function automatic void add_sequence();
    int unsigned start;
    start = plan_q.size();
    case ($urandom_range(0, 19))
      0, 1: begin
        repeat ($urandom_range(1, 8)) add_noise();
      end
      2, 3: begin
        add_expr(0, $urandom_range(6, 12), 1'b1);
      end
      default: begin
        add_expr(0, 3, 1'b0);
      end
    endcase
    if ($urandom_range(0, 9) == 0 && plan_q.size() > start)
      plan_q.delete($urandom_range(start, plan_q.size() - 1));
    if ($urandom_range(0, 9) != 0) add_operator(OP_END);
  endfunction

  task automatic idle_for(int unsigned cycles);
    if (cycles > 0) begin
      tok_if.valid = 1'b0;
      tok_if.func = 1'($urandom_range(0, 1));
      tok_if.operand_value = $urandom;
      tok_if.operator_code = 3'($urandom_range(0, 7));
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic send_token(token_t t);
    tok_if.valid = 1'b1;
    tok_if.func = t.kind;
    tok_if.operand_value = t.value;
    tok_if.operator_code = t.code;
    do @(posedge clk_i); while (tok_if.ready !== 1'b1);
    postfix_sb.note_token(t);
    @(negedge clk_i);
  endtask

  task automatic run_plan();
    token_t t;
    while (plan_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 10);
        idle_for($urandom_range(0, 6));
      end
      t = plan_q.pop_front();
      send_token(t);
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (postfix_sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    tok_if.valid = 1'b0;
    tok_if.func = 1'b0;
    tok_if.operand_value = '0;
    tok_if.operator_code = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extreme operands with every arithmetic operator, then the end token.
    add_operand(32'sh8000_0000);
    add_operator(OP_PLUS);
    add_operand(32'sh7FFF_FFFF);
    add_operator(OP_TIMES);
    add_operand(-32'sd1);
    add_operator(OP_MINUS);
    add_operand(32'sd0);
    add_operator(OP_DIVIDE);
    add_operator(OP_END);
    // A stray close paren, removed by an open paren that then matches a close
    // paren around an ignored code, and a stray close paren popped by a plus.
    add_operator(OP_CLOSE);
    add_operator(OP_OPEN);
    add_operator(CODE_UNUSED);
    add_operator(OP_CLOSE);
    add_operator(OP_CLOSE);
    add_operator(OP_PLUS);
    add_operator(OP_END);
    // Fill the stack, drop one push, and drain the whole stack.
    repeat (STACK_DEPTH) add_operator(OP_OPEN);
    add_operator(OP_END);
    run_plan();
    wait_drained();

    for (int round = 0; round < ROUNDS; round++) begin
      while (plan_q.size() < ROUND_TOKENS) add_sequence();
      run_plan();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d tokens and %0d postfix results.",
             postfix_sb.tokens, postfix_sb.results);
    $display("Results included %0d completed expressions and %0d dropped pushes.",
             postfix_sb.exprs_done, postfix_sb.pushes_dropped);
    if (postfix_sb.errors == 0 && postfix_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected.", postfix_sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_front.sv
rtl/itp_fifo.sv
rtl/itp_back.sv
rtl/infix_to_postfix_converter_core.sv
test/infix_to_postfix_converter_core_tb.sv
